// ===== hw/rtl/ifb_pkg.sv =====
// Shared types and constants for the serial frame parser with sensor telemetry.
// Used by the controller, datapath and top level; depends on nothing.
`default_nettype none

package ifb_pkg;

  localparam int unsigned FrameOverhead = 3;

  localparam logic [1:0] OP_RX  = 2'd0;
  localparam logic [1:0] OP_REG = 2'd1;
  localparam logic [1:0] OP_SET = 2'd2;

  localparam logic [7:0]  CMD_CHANNELS  = 8'h40;
  localparam logic [3:0]  POLL_DISCOVER = 4'h8;
  localparam logic [3:0]  POLL_TYPE     = 4'h9;
  localparam logic [3:0]  POLL_VALUE    = 4'hA;
  localparam logic [7:0]  LEN_DISCOVER  = 8'h04;
  localparam logic [7:0]  LEN_TYPE      = 8'h06;
  localparam logic [15:0] CHK_INIT      = 16'hFFFF;
  localparam logic [2:0]  SIZE_LONG     = 3'd4;
  localparam logic [2:0]  SIZE_SHORT    = 3'd2;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_CHAN = 2'd1,
    KIND_REG  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_DISCARD = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_DATA    = 2'd2,
    PH_CHECK   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_REG   = 2'd1,
    RES_CHAN  = 2'd2,
    RES_REPLY = 2'd3
  } res_e;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RD_LO = 6'b000010,
    ST_RD_HI = 6'b000100,
    ST_LD_CH = 6'b001000,
    ST_LD_RP = 6'b010000,
    ST_SEND  = 6'b100000
  } state_e;

  typedef struct packed {
    logic accept;
    logic load_reg;
    logic rd_hi;
    logic cap_lo;
    logic ld_ch;
    logic ld_rp;
    logic next;
  } cmd_t;

  typedef struct packed {
    res_e res;
    logic last;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ifb_if.sv =====
// Valid/ready channel interfaces for input words and result words.
// Depends on nothing.
`default_nettype none

interface ifb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [7:0]         rx_byte;
  logic               gap_before;
  logic [7:0]         sensor_type;
  logic [7:0]         sensor_length;
  logic [3:0]         sensor_slot;
  logic signed [31:0] sensor_value;

  modport source (output valid, op, rx_byte, gap_before, sensor_type, sensor_length,
                  sensor_slot, sensor_value, input ready);
  modport sink   (input valid, op, rx_byte, gap_before, sensor_type, sensor_length,
                  sensor_slot, sensor_value, output ready);
endinterface

interface ifb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [3:0]  channel_index;
  logic [15:0] channel_value;
  logic [3:0]  registered_count;
  logic        last;

  modport source (output valid, kind, tx_byte, channel_index, channel_value,
                  registered_count, last, input ready);
  modport sink   (input valid, kind, tx_byte, channel_index, channel_value,
                  registered_count, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ifb_ctrl.sv =====
// Controller: sequences word intake, frame store reads and result delivery.
// Depends on ifb_pkg.
`default_nettype none

module ifb_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire ifb_pkg::status_t status_i,
  output ifb_pkg::cmd_t         cmd_o
);

  ifb_pkg::state_e state_q, state_d;
  ifb_pkg::res_e   mode_q, mode_d;

  assign in_ready_o  = (state_q == ifb_pkg::ST_IDLE);
  assign out_valid_o = (state_q == ifb_pkg::ST_SEND);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cmd_o   = '0;
    case (state_q)
      ifb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          mode_d       = status_i.res;
          case (status_i.res)
            ifb_pkg::RES_REG: begin
              cmd_o.load_reg = 1'b1;
              state_d        = ifb_pkg::ST_SEND;
            end
            ifb_pkg::RES_CHAN:  state_d = ifb_pkg::ST_RD_LO;
            ifb_pkg::RES_REPLY: state_d = ifb_pkg::ST_LD_RP;
            default:            state_d = ifb_pkg::ST_IDLE;
          endcase
        end
      end
      ifb_pkg::ST_RD_LO: state_d = ifb_pkg::ST_RD_HI;
      ifb_pkg::ST_RD_HI: begin
        cmd_o.rd_hi  = 1'b1;
        cmd_o.cap_lo = 1'b1;
        state_d      = ifb_pkg::ST_LD_CH;
      end
      ifb_pkg::ST_LD_CH: begin
        cmd_o.ld_ch = 1'b1;
        state_d     = ifb_pkg::ST_SEND;
      end
      ifb_pkg::ST_LD_RP: begin
        cmd_o.ld_rp = 1'b1;
        state_d     = ifb_pkg::ST_SEND;
      end
      ifb_pkg::ST_SEND: begin
        if (out_ready_i) begin
          if (status_i.last) begin
            state_d = ifb_pkg::ST_IDLE;
          end else begin
            cmd_o.next = 1'b1;
            state_d    = (mode_q == ifb_pkg::RES_CHAN) ? ifb_pkg::ST_RD_LO
                                                        : ifb_pkg::ST_LD_RP;
          end
        end
      end
      default: state_d = ifb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ifb_pkg::ST_IDLE;
      mode_q  <= ifb_pkg::RES_NONE;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ifb_dpath.sv =====
// Datapath: frame parsing, frame store, sensor registry and result word registers.
// Depends on ifb_pkg; driven by ifb_ctrl through cmd_t.
`default_nettype none

module ifb_dpath #(
  parameter int NumChannels = 14,
  parameter int MaxSensors  = 10,
  parameter int MaxFrame    = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [1:0]         op_i,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic               gap_before_i,
  input  wire logic [7:0]         sensor_type_i,
  input  wire logic [7:0]         sensor_length_i,
  input  wire logic [3:0]         sensor_slot_i,
  input  wire logic signed [31:0] sensor_value_i,
  input  wire ifb_pkg::cmd_t      cmd_i,
  output ifb_pkg::status_t        status_o,
  output ifb_pkg::kind_e          kind_o,
  output logic [7:0]              tx_byte_o,
  output logic [3:0]              channel_index_o,
  output logic [15:0]             channel_value_o,
  output logic [3:0]              registered_count_o,
  output logic                    last_o
);

  localparam int Depth = MaxFrame - ifb_pkg::FrameOverhead;
  localparam int AW    = $clog2(Depth);
  localparam int SW    = (MaxSensors > 1) ? $clog2(MaxSensors) : 1;
  localparam int CW    = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  // parser state
  ifb_pkg::phase_e phase_q;
  logic [4:0]       idx_q;
  logic [4:0]       total_q;
  logic [15:0]      chk_q;
  logic [7:0]       lo_q;
  logic [7:0]       cmd_q;
  logic [Depth-1:0] vld_q;
  logic [7:0]       mem [Depth];
  logic [3:0]       stotal_q;
  logic [7:0]       s_type [MaxSensors];
  logic [2:0]       s_size [MaxSensors];
  logic [31:0]      s_val  [MaxSensors];

  // result sequencing
  logic [CW-1:0] ch_q;
  logic [7:0]    rdata_q;
  logic          rok_q;
  logic [7:0]    chlo_q;
  logic [7:0]    rp_cmd_q;
  logic [7:0]    rp_type_q;
  logic [2:0]    rp_len_q;
  logic [31:0]   rp_val_q;
  logic [2:0]    rp_np_q;
  logic [2:0]    rp_j_q;
  logic [15:0]   rchk_q;

  ifb_pkg::phase_e phase_eff;
  logic            is_rx;
  logic            frame_ok;
  logic            poll_ok;
  logic [3:0]      poll_nib;
  logic [3:0]      poll_addr;
  logic [3:0]      poll_idx;
  logic [3:0]      slot_idx;
  logic            reg_room;
  logic            set_ok;
  logic [4:0]      rd_addr;
  logic [7:0]      pay_byte;
  logic [3:0]      rp_end;

  assign is_rx     = (op_i == ifb_pkg::OP_RX);
  assign phase_eff = gap_before_i ? ifb_pkg::PH_LENGTH : phase_q;
  assign frame_ok  = (phase_eff == ifb_pkg::PH_CHECK) && (idx_q != total_q) &&
                     (chk_q == {rx_byte_i, lo_q});
  assign poll_nib  = cmd_q[7:4];
  assign poll_addr = cmd_q[3:0];
  assign poll_idx  = poll_addr - 4'd1;
  assign poll_ok   = (poll_addr != 4'd0) && (poll_addr <= stotal_q) && (total_q == 5'd1) &&
                     ((poll_nib == ifb_pkg::POLL_DISCOVER) || (poll_nib == ifb_pkg::POLL_TYPE) ||
                      (poll_nib == ifb_pkg::POLL_VALUE));
  assign reg_room  = (stotal_q < 4'(MaxSensors));
  assign slot_idx  = sensor_slot_i - 4'd1;
  assign set_ok    = (sensor_slot_i != 4'd0) && (sensor_slot_i <= stotal_q);

  always_comb begin
    status_o.last = last_o;
    if (is_rx && frame_ok && (cmd_q == ifb_pkg::CMD_CHANNELS)) begin
      status_o.res = ifb_pkg::RES_CHAN;
    end else if (is_rx && frame_ok && poll_ok) begin
      status_o.res = ifb_pkg::RES_REPLY;
    end else if (op_i == ifb_pkg::OP_REG) begin
      status_o.res = ifb_pkg::RES_REG;
    end else begin
      status_o.res = ifb_pkg::RES_NONE;
    end
  end

  // parser and registry control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ifb_pkg::PH_DISCARD;
      idx_q    <= '0;
      total_q  <= '0;
      chk_q    <= '0;
      lo_q     <= '0;
      cmd_q    <= '0;
      vld_q    <= '0;
      stotal_q <= '0;
    end else if (cmd_i.accept) begin
      if (is_rx) begin
        case (phase_eff)
          ifb_pkg::PH_LENGTH: begin
            if ((rx_byte_i <= 8'(MaxFrame)) && (rx_byte_i > 8'(ifb_pkg::FrameOverhead))) begin
              idx_q   <= '0;
              total_q <= 5'(rx_byte_i - 8'(ifb_pkg::FrameOverhead));
              chk_q   <= ifb_pkg::CHK_INIT - {8'd0, rx_byte_i};
              phase_q <= ifb_pkg::PH_DATA;
            end else begin
              phase_q <= ifb_pkg::PH_DISCARD;
            end
          end
          ifb_pkg::PH_DATA: begin
            if (idx_q >= 5'(Depth)) begin
              phase_q <= ifb_pkg::PH_DISCARD;
            end else begin
              vld_q[idx_q[AW-1:0]] <= 1'b1;
              if (idx_q == 5'd0) begin
                cmd_q <= rx_byte_i;
              end
              idx_q <= idx_q + 5'd1;
              chk_q <= chk_q - {8'd0, rx_byte_i};
              if ((idx_q + 5'd1) >= total_q) begin
                phase_q <= ifb_pkg::PH_CHECK;
              end else begin
                phase_q <= ifb_pkg::PH_DATA;
              end
            end
          end
          ifb_pkg::PH_CHECK: begin
            if (idx_q == total_q) begin
              lo_q    <= rx_byte_i;
              idx_q   <= idx_q + 5'd1;
              phase_q <= ifb_pkg::PH_CHECK;
            end else begin
              phase_q <= ifb_pkg::PH_DISCARD;
            end
          end
          default: phase_q <= ifb_pkg::PH_DISCARD;
        endcase
      end else if ((op_i == ifb_pkg::OP_REG) && reg_room) begin
        stotal_q <= stotal_q + 4'd1;
      end
    end
  end

  // frame store and sensor tables, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_rx && (phase_eff == ifb_pkg::PH_DATA) && (idx_q < 5'(Depth))) begin
      mem[idx_q[AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.accept && (op_i == ifb_pkg::OP_REG) && reg_room) begin
      s_type[stotal_q[SW-1:0]] <= sensor_type_i;
      s_size[stotal_q[SW-1:0]] <= (sensor_length_i == 8'd4) ? ifb_pkg::SIZE_LONG
                                                             : ifb_pkg::SIZE_SHORT;
      s_val[stotal_q[SW-1:0]]  <= '0;
    end else if (cmd_i.accept && (op_i == ifb_pkg::OP_SET) && set_ok) begin
      s_val[slot_idx[SW-1:0]] <= sensor_value_i;
    end
  end

  // frame store read port
  assign rd_addr = {4'(ch_q), 1'b0} + (cmd_i.rd_hi ? 5'd2 : 5'd1);

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[rd_addr[AW-1:0]];
    rok_q   <= (rd_addr < 5'(Depth)) && vld_q[rd_addr[AW-1:0]];
  end

  assign rp_end = {1'b0, rp_np_q} + 4'd1;

  always_comb begin
    case (rp_j_q)
      3'd0: begin
        case (rp_cmd_q[7:4])
          ifb_pkg::POLL_DISCOVER: pay_byte = ifb_pkg::LEN_DISCOVER;
          ifb_pkg::POLL_TYPE:     pay_byte = ifb_pkg::LEN_TYPE;
          default:                pay_byte = ifb_pkg::LEN_DISCOVER + {5'd0, rp_len_q};
        endcase
      end
      3'd1: pay_byte = rp_cmd_q;
      3'd2: pay_byte = (rp_cmd_q[7:4] == ifb_pkg::POLL_TYPE) ? rp_type_q : rp_val_q[7:0];
      3'd3: pay_byte = (rp_cmd_q[7:4] == ifb_pkg::POLL_TYPE) ? {5'd0, rp_len_q}
                                                             : rp_val_q[15:8];
      3'd4: pay_byte = rp_val_q[23:16];
      default: pay_byte = rp_val_q[31:24];
    endcase
  end

  // result sequencing and output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ch_q     <= '0;
      rp_j_q   <= '0;
      rchk_q   <= ifb_pkg::CHK_INIT;
      rp_cmd_q <= cmd_q;
      rp_type_q <= s_type[poll_idx[SW-1:0]];
      rp_len_q  <= s_size[poll_idx[SW-1:0]];
      rp_val_q  <= s_val[poll_idx[SW-1:0]];
      case (poll_nib)
        ifb_pkg::POLL_DISCOVER: rp_np_q <= 3'd2;
        ifb_pkg::POLL_TYPE:     rp_np_q <= 3'd4;
        default: rp_np_q <= (s_size[poll_idx[SW-1:0]] == ifb_pkg::SIZE_LONG) ? 3'd6 : 3'd4;
      endcase
    end
    if (cmd_i.next) begin
      ch_q   <= ch_q + CW'(1);
      rp_j_q <= rp_j_q + 3'd1;
    end
    if (cmd_i.cap_lo) begin
      chlo_q <= rok_q ? rdata_q : 8'd0;
    end
    if (cmd_i.load_reg) begin
      kind_o             <= ifb_pkg::KIND_REG;
      tx_byte_o          <= '0;
      channel_index_o    <= '0;
      channel_value_o    <= '0;
      registered_count_o <= reg_room ? (stotal_q + 4'd1) : stotal_q;
      last_o             <= 1'b1;
    end else if (cmd_i.ld_ch) begin
      kind_o             <= ifb_pkg::KIND_CHAN;
      tx_byte_o          <= '0;
      channel_index_o    <= 4'(ch_q);
      channel_value_o    <= {(rok_q ? rdata_q : 8'd0), chlo_q};
      registered_count_o <= '0;
      last_o             <= (ch_q == CW'(NumChannels - 1));
    end else if (cmd_i.ld_rp) begin
      kind_o             <= ifb_pkg::KIND_TX;
      channel_index_o    <= '0;
      channel_value_o    <= '0;
      registered_count_o <= '0;
      last_o             <= ({1'b0, rp_j_q} == rp_end);
      if (rp_j_q < rp_np_q) begin
        tx_byte_o <= pay_byte;
        rchk_q    <= rchk_q - {8'd0, pay_byte};
      end else if (rp_j_q == rp_np_q) begin
        tx_byte_o <= rchk_q[7:0];
      end else begin
        tx_byte_o <= rchk_q[15:8];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ibus_frame_parser_with_telemetry.sv =====
// Serial frame parser with sensor telemetry replies (top level).
// Usage:
//   in_i  : one word per received byte (op 0, with gap flag) or a sensor
//           registration (op 1) or sensor value update (op 2).
//   out_o : result words: reply bytes, channel updates or registration counts;
//           last marks the final word caused by an input word.
// Sequencing:
//   A word that causes no result leaves in_i ready for the next word. A
//   registration answer is shown the cycle after intake. A channel burst
//   takes, for each channel, two reads of the single frame store port, the
//   load and the send state, plus receiver stalls. A reply byte takes a
//   load state and a send state each.
//   One word is processed at a time; in_i.ready returns the cycle after the
//   last result word is taken.
// Reset: parser goes to discard, frame store reads as zero, no sensors are
//   registered. Reset is asynchronous, active low.
// Stall: out_o holds its word while out_o.ready is low; no input is taken.
`default_nettype none

module ibus_frame_parser_with_telemetry #(
  parameter int NUM_CHANNELS = 14,
  parameter int MAX_SENSORS  = 10,
  parameter int MAX_FRAME    = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ifb_in_if.sink     in_i,
  ifb_out_if.source  out_o
);

  ifb_pkg::cmd_t    cmd;
  ifb_pkg::status_t status;
  ifb_pkg::kind_e   kind;

  ifb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ifb_dpath #(
    .NumChannels (NUM_CHANNELS),
    .MaxSensors  (MAX_SENSORS),
    .MaxFrame    (MAX_FRAME)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .op_i               (in_i.op),
    .rx_byte_i          (in_i.rx_byte),
    .gap_before_i       (in_i.gap_before),
    .sensor_type_i      (in_i.sensor_type),
    .sensor_length_i    (in_i.sensor_length),
    .sensor_slot_i      (in_i.sensor_slot),
    .sensor_value_i     (in_i.sensor_value),
    .cmd_i              (cmd),
    .status_o           (status),
    .kind_o             (kind),
    .tx_byte_o          (out_o.tx_byte),
    .channel_index_o    (out_o.channel_index),
    .channel_value_o    (out_o.channel_value),
    .registered_count_o (out_o.registered_count),
    .last_o             (out_o.last)
  );

  assign out_o.kind = kind;

`ifndef SYNTH
  logic in_acc;
  logic out_acc;
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  a_reg_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.op == ifb_pkg::OP_REG)) |=>
      (out_o.valid && out_o.last && (out_o.kind == ifb_pkg::KIND_REG)))
    else $error("registration answer missing");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input taken while a result is pending");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind == ifb_pkg::KIND_CHAN)) |->
      (out_o.channel_index < 4'(NUM_CHANNELS)))
    else $error("channel index out of range");

  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.last) |=> in_i.ready)
    else $error("not ready after final result");
`endif

endmodule

`default_nettype wire

// ===== test/tb_ibus_frame_parser_with_telemetry_chk.sv =====
// Scoreboard for the frame parser: watches both channels, predicts the result words
// from each accepted input word and compares them. Depends on ifb_pkg and ifb_if.
`default_nettype none

module tb_ibus_frame_parser_with_telemetry_chk (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ifb_in_if         in_w,
  ifb_out_if        out_w,
  output int        errors_o,
  output int        pending_o,
  output int        words_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ifb_pkg::*;

  localparam int NumChan = 14;
  localparam int MaxSens = 10;
  localparam int StoreDepth = 29;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic [3:0]  registered_count;
    logic        last;
  } result_t;

  phase_e      phase;
  logic [4:0]  idx, total;
  logic [15:0] sum;
  logic [7:0]  chk_lo;
  logic [7:0]  frame_mem [StoreDepth];
  int          n_sens;
  logic [7:0]  s_type [MaxSens];
  logic [2:0]  s_size [MaxSens];
  logic [31:0] s_val  [MaxSens];
  result_t     want_q [$];
  int          errors;

  assign errors_o  = errors;
  assign pending_o = want_q.size();

  function automatic logic [7:0] frame_byte(int i);
    return (i < StoreDepth) ? frame_mem[i] : 8'h00;
  endfunction

  function automatic result_t mk(logic [1:0] k, logic [7:0] tx, logic [3:0] ci,
                                 logic [15:0] cv, logic [3:0] rc);
    result_t r;
    r = '{kind: k, tx_byte: tx, channel_index: ci, channel_value: cv,
          registered_count: rc, last: 1'b0};
    return r;
  endfunction

  task automatic push_tx(ref result_t q[$], ref logic [15:0] c, input logic [7:0] b);
    q.push_back(mk(KIND_TX, b, 0, 0, 0));
    c = c - 16'(b);
  endtask

  task automatic decode_frame(ref result_t q[$]);
    logic [7:0]  cmd;
    logic [3:0]  addr;
    logic [15:0] c;
    int          s;
    cmd  = frame_byte(0);
    addr = cmd[3:0];
    c    = CHK_INIT;
    if (cmd == CMD_CHANNELS) begin
      for (int ch = 0; ch < NumChan; ch++)
        q.push_back(mk(KIND_CHAN, 0, 4'(ch),
                       {frame_byte(2*ch+2), frame_byte(2*ch+1)}, 0));
    end else if (addr > 0 && addr <= n_sens && total == 1) begin
      s = addr - 1;
      case (cmd[7:4])
        POLL_DISCOVER: begin
          push_tx(q, c, LEN_DISCOVER);
          push_tx(q, c, 8'h80 + addr);
        end
        POLL_TYPE: begin
          push_tx(q, c, LEN_TYPE);
          push_tx(q, c, 8'h90 + addr);
          push_tx(q, c, s_type[s]);
          push_tx(q, c, 8'(s_size[s]));
        end
        POLL_VALUE: begin
          push_tx(q, c, 8'h04 + s_size[s]);
          push_tx(q, c, 8'hA0 + addr);
          push_tx(q, c, s_val[s][7:0]);
          push_tx(q, c, s_val[s][15:8]);
          if (s_size[s] == SIZE_LONG) begin
            push_tx(q, c, s_val[s][23:16]);
            push_tx(q, c, s_val[s][31:24]);
          end
        end
        default: return;
      endcase
      q.push_back(mk(KIND_TX, c[7:0], 0, 0, 0));
      q.push_back(mk(KIND_TX, c[15:8], 0, 0, 0));
    end
  endtask

  task automatic predict_word();
    result_t q[$];
    logic [7:0] b;
    b = in_w.rx_byte;
    case (in_w.op)
      OP_RX: begin
        if (in_w.gap_before) phase = PH_LENGTH;
        case (phase)
          PH_LENGTH:
            if (b <= 32 && b > FrameOverhead) begin
              idx = 0;
              total = 5'(b - FrameOverhead);
              sum = CHK_INIT - 16'(b);
              phase = PH_DATA;
            end else phase = PH_DISCARD;
          PH_DATA: begin
            frame_mem[idx] = b;
            idx++;
            sum = sum - 16'(b);
            if (idx >= total) phase = PH_CHECK;
          end
          PH_CHECK:
            if (idx == total) begin
              chk_lo = b;
              idx++;
            end else begin
              if (sum == {b, chk_lo}) decode_frame(q);
              phase = PH_DISCARD;
            end
          default: ;
        endcase
      end
      OP_REG: begin
        if (n_sens < MaxSens) begin
          s_type[n_sens] = in_w.sensor_type;
          s_size[n_sens] = (in_w.sensor_length == 8'd4) ? SIZE_LONG : SIZE_SHORT;
          s_val[n_sens]  = 0;
          n_sens++;
        end
        q.push_back(mk(KIND_REG, 0, 0, 0, 4'(n_sens)));
      end
      OP_SET:
        if (in_w.sensor_slot > 0 && in_w.sensor_slot <= n_sens)
          s_val[in_w.sensor_slot - 1] = in_w.sensor_value;
      default: ;
    endcase
    if (q.size() > 0) q[$].last = 1'b1;
    foreach (q[i]) want_q.push_back(q[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase  <= PH_DISCARD;
      idx    <= '0;
      total  <= '0;
      sum    <= '0;
      chk_lo <= '0;
      n_sens <= 0;
      errors <= 0;
      words_o <= 0;
      foreach (frame_mem[i]) frame_mem[i] <= '0;
      want_q.delete();
    end else begin
      if (in_w.valid && in_w.ready) predict_word();
      if (out_w.valid && out_w.ready) begin
        result_t got, exp_r;
        got = '{kind: out_w.kind, tx_byte: out_w.tx_byte,
                channel_index: out_w.channel_index, channel_value: out_w.channel_value,
                registered_count: out_w.registered_count, last: out_w.last};
        words_o <= words_o + 1;
        if (want_q.size() == 0) begin
          if (errors < 10) $display("unexpected result word %h", got);
          errors <= errors + 1;
        end else begin
          exp_r = want_q.pop_front();
          if (got !== exp_r) begin
            if (errors < 10)
              $display({"mismatch: exp kind %0d tx %h ch %0d val %h cnt %0d last %0d",
                        " / got kind %0d tx %h ch %0d val %h cnt %0d last %0d"},
                       exp_r.kind, exp_r.tx_byte, exp_r.channel_index, exp_r.channel_value,
                       exp_r.registered_count, exp_r.last, got.kind, got.tx_byte,
                       got.channel_index, got.channel_value, got.registered_count, got.last);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_ibus_frame_parser_with_telemetry.sv =====
// Testbench top: drives bursty frame and sensor traffic into the parser and gives the
// verdict. Depends on ifb_pkg, ifb_if, the parser and the scoreboard module.
`default_nettype none

module tb_ibus_frame_parser_with_telemetry;
  timeunit 1ns;
  timeprecision 1ps;
  import ifb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending, words_seen;
  int   sent = 0;
  bit   hold_off = 1'b0;
  int   n_reg = 0;

  ifb_in_if  in_w ();
  ifb_out_if out_w ();

  ibus_frame_parser_with_telemetry uut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_w),
                                        .out_o(out_w));

  tb_ibus_frame_parser_with_telemetry_chk chk (.clk_i(clk_i), .rst_ni(rst_ni), .in_w(in_w),
                                               .out_w(out_w), .errors_o(errors),
                                               .pending_o(pending), .words_o(words_seen));

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: stall in a repeating pattern with a random mix, plus the long hold-off.
  initial begin
    int ph;
    ph = 0;
    out_w.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      ph = (ph + 1) % 64;
      if (hold_off) out_w.ready <= 1'b0;
      else if (ph < 24) out_w.ready <= 1'b1;
      else out_w.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    wait (sent >= 150);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  byte unsigned frame_q [$];
  logic [7:0] word_gap_q [$];

  task automatic send_word(logic [1:0] op, logic [7:0] b, logic gap, logic [7:0] st,
                           logic [7:0] sl, logic [3:0] slot, logic [31:0] val);
    in_w.valid         <= 1'b1;
    in_w.op            <= op;
    in_w.rx_byte       <= b;
    in_w.gap_before    <= gap;
    in_w.sensor_type   <= st;
    in_w.sensor_length <= sl;
    in_w.sensor_slot   <= slot;
    in_w.sensor_value  <= val;
    do @(posedge clk_i); while (!in_w.ready);
    sent++;
    // gap between bursts
    if ($urandom_range(0, 5) == 0) begin
      in_w.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_rx(logic [7:0] b, logic gap);
    send_word(OP_RX, b, gap, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Send a frame from data bytes; corrupt flips one bit of the checksum.
  task automatic send_frame(byte unsigned d[$], bit corrupt);
    logic [15:0] c;
    logic [7:0]  len;
    len = 8'(d.size() + FrameOverhead);
    c = CHK_INIT - 16'(len);
    foreach (d[i]) c = c - 16'(d[i]);
    if (corrupt) c = c ^ 16'(1 << $urandom_range(0, 15));
    send_rx(len, 1'b1);
    foreach (d[i]) send_rx(d[i], 1'b0);
    send_rx(c[7:0], 1'b0);
    send_rx(c[15:8], 1'b0);
  endtask

  task automatic send_reg(logic [7:0] t, logic [7:0] l);
    send_word(OP_REG, $urandom, $urandom, t, l, $urandom, $urandom);
    n_reg++;
  endtask

  task automatic send_poll(logic [3:0] kind_nib, logic [3:0] addr);
    byte unsigned d[$];
    d = '{ {kind_nib, addr} };
    send_frame(d, 1'b0);
  endtask

  task automatic send_channels(int n, bit corrupt);
    byte unsigned d[$];
    d = '{CMD_CHANNELS};
    repeat (n) d.push_back(8'($urandom));
    send_frame(d, corrupt);
  endtask

  initial begin
    int r;
    byte unsigned d[$];
    in_w.valid = 1'b0;
    in_w.op = OP_RX;
    in_w.rx_byte = '0;
    in_w.gap_before = 1'b0;
    in_w.sensor_type = '0;
    in_w.sensor_length = '0;
    in_w.sensor_slot = '0;
    in_w.sensor_value = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: stale store, bad lengths, discard, registry, polls, ops 2 and 3.
    send_channels(0, 1'b0);
    send_rx(8'hFF, 1'b0);
    send_rx(8'd3, 1'b1);
    send_rx(8'd33, 1'b1);
    send_channels(28, 1'b0);
    send_channels(3, 1'b1);
    send_reg(8'hFF, 8'd4);
    send_reg(8'h00, 8'd0);
    send_word(OP_SET, 0, 0, 0, 0, 4'd1, 32'h8000_0000);
    send_word(OP_SET, 0, 0, 0, 0, 4'd0, 32'h7FFF_FFFF);
    send_word(OP_SET, 0, 0, 0, 0, 4'd15, 32'hFFFF_FFFF);
    send_word(OP_SET, 0, 0, 0, 0, 4'd2, 32'h7FFF_ABCD);
    send_word(2'd3, 8'hFF, 1'b1, 8'hFF, 8'hFF, 4'hF, 32'hFFFF_FFFF);
    send_poll(POLL_DISCOVER, 4'd1);
    send_poll(POLL_TYPE, 4'd2);
    send_poll(POLL_VALUE, 4'd1);
    send_poll(POLL_VALUE, 4'd2);
    send_poll(POLL_VALUE, 4'd5);
    send_poll(4'hC, 4'd1);
    d = '{8'h81, 8'h00};
    send_frame(d, 1'b0);
    for (int i = 0; i < 9; i++) send_reg(8'($urandom), (i % 2) ? 8'd4 : 8'($urandom));

    // Random: mostly well-formed frames with random content, some noise.
    while (sent < 370) begin
      r = $urandom_range(0, 99);
      if (r < 25) send_channels($urandom_range(0, 29), $urandom_range(0, 7) == 0);
      else if (r < 55) send_poll(4'($urandom_range(7, 11)), 4'($urandom_range(0, 12)));
      else if (r < 65) send_word(OP_SET, $urandom, $urandom, $urandom, $urandom,
                                 4'($urandom_range(0, 12)), $urandom);
      else if (r < 70) begin
        d.delete();
        repeat ($urandom_range(0, 6)) d.push_back(8'($urandom));
        send_frame(d, $urandom_range(0, 1));
      end else if (r < 72) send_word(OP_REG, $urandom, $urandom, $urandom,
                                     $urandom_range(0, 1) ? 8'd4 : 8'($urandom), 0, 0);
      else if (r < 74) send_word(2'd3, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom);
      else send_rx($urandom, $urandom_range(0, 3) == 0);
    end
    in_w.valid <= 1'b0;

    fork
      begin
        wait (pending == 0);
        repeat (100) @(posedge clk_i);
      end
      begin
        repeat (200_000) @(posedge clk_i);
      end
    join_any
    $display("Covered %0d input words and %0d result words (frames, polls, registrations).",
             sent, words_seen);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/ifb_pkg.sv
hw/rtl/ifb_if.sv
hw/rtl/ifb_ctrl.sv
hw/rtl/ifb_dpath.sv
hw/rtl/ibus_frame_parser_with_telemetry.sv
test/tb_ibus_frame_parser_with_telemetry_chk.sv
test/tb_ibus_frame_parser_with_telemetry.sv
